// File: hdl/oahm_pkg.sv
package oahm_pkg;

	// default sizes
	localparam int unsigned MAX_SLOTS_DEF  = 1024;
	localparam int unsigned MIN_SLOTS_DEF  = 8;
	localparam int unsigned KEY_BITS_DEF   = 32;
	localparam int unsigned VALUE_BITS_DEF = 32;

	// growth and probe rule constants
	localparam int unsigned GROW_HALF_LIMIT = 50000;
	localparam int unsigned PROBE_EXTRA     = 8;
	localparam int unsigned PERTURB_SHIFT   = 5;

	localparam logic [31:0] INVALID_HASH_RST = 32'hFFFF_FFFF;

	// request codes
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	// response codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_BAD_HASH  = 2'd2;
	localparam logic [1:0] STATUS_FULL      = 2'd3;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_LIVE  = 2'd1,
		MARK_TOMB  = 2'd2
	} mark_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_PRB_RD,
		ST_PRB_CHK,
		ST_GRW_SIZE,
		ST_GRW_RD,
		ST_GRW_CHK,
		ST_GRW_NEXT,
		ST_FINISH
	} state_t;

endpackage

// File: hdl/oahm_if.sv
interface oahm_req_if #(
	parameter int unsigned KEY_BITS   = oahm_pkg::KEY_BITS_DEF,
	parameter int unsigned VALUE_BITS = oahm_pkg::VALUE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            op;
	logic [KEY_BITS-1:0]   key;
	logic [31:0]           hash_code;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, op, key, hash_code, value, input ready);
	modport sink (input valid, op, key, hash_code, value, output ready);
endinterface

interface oahm_rsp_if #(
	parameter int unsigned VALUE_BITS = oahm_pkg::VALUE_BITS_DEF,
	parameter int unsigned CNT_BITS   = 11
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            status;
	logic [VALUE_BITS-1:0] value_out;
	logic [CNT_BITS-1:0]   live_count;

	modport source (output valid, status, value_out, live_count, input ready);
	modport sink (input valid, status, value_out, live_count, output ready);
endinterface

interface oahm_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// File: hdl/open_addressing_hash_map_unit.sv
// Key/value map with open addressing and perturbed probing, one request word in and one
// response word out. Each probe step is a memory read, then a compare, through a single
// shared read port of the slot memory. An insert that pushes the fill past two thirds of
// the table size less one triggers a rehash into the other bank: a size search, a
// clearing pass of the new size, then a walk over every old slot (read, check, next) that
// re-probes and places each live entry. A clear request sweeps the active table once,
// one slot per cycle. After reset the block clears its first table of MIN_SLOTS slots
// before it takes a request; invalid_hash writes are taken at any time.
module open_addressing_hash_map_unit #(
	parameter int unsigned MAX_SLOTS  = oahm_pkg::MAX_SLOTS_DEF,
	parameter int unsigned MIN_SLOTS  = oahm_pkg::MIN_SLOTS_DEF,
	parameter int unsigned KEY_BITS   = oahm_pkg::KEY_BITS_DEF,
	parameter int unsigned VALUE_BITS = oahm_pkg::VALUE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	oahm_req_if.sink   req,
	oahm_rsp_if.source rsp,
	oahm_cfg_if.sink   cfg
);

	localparam int unsigned SB    = $clog2(MAX_SLOTS);
	localparam int unsigned CB    = SB + 1;
	localparam int unsigned NB    = $clog2(MAX_SLOTS + oahm_pkg::PROBE_EXTRA);
	localparam int unsigned DEPTH = 2 * MAX_SLOTS;
	localparam logic [NB-1:0] LAST_STEP = NB'(MAX_SLOTS + oahm_pkg::PROBE_EXTRA - 1);

	// slot memories, two banks
	logic [KEY_BITS-1:0]   key_mem  [DEPTH];
	logic [VALUE_BITS-1:0] val_mem  [DEPTH];
	logic [31:0]           code_mem [DEPTH];
	oahm_pkg::mark_t       mark_mem [DEPTH];

	oahm_pkg::state_t state_q, state_d, clr_ret_q;

	logic [1:0]            op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [31:0]           code_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [31:0]           perturb_q;
	logic [31:0]           inv_hash_q;
	logic [SB-1:0]         i_q, free_q, mask_q, old_mask_q, clr_idx_q, clr_last_q;
	logic [NB-1:0]         n_q;
	logic                  have_free_q, placing_q, bank_q, clr_bank_q;
	logic [CB-1:0]         fill_q, used_q, j_q, size_q;
	logic [CB+1:0]         need_q;
	logic [1:0]            status_q;
	logic [VALUE_BITS-1:0] found_q;

	logic                  out_valid_q;
	logic [1:0]            out_status_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic [CB-1:0]         out_count_q;

	logic [KEY_BITS-1:0]   rd_key_q;
	logic [VALUE_BITS-1:0] rd_val_q;
	logic [31:0]           rd_code_q;
	oahm_pkg::mark_t       rd_mark_q;

	logic [SB:0]           rd_addr, wr_addr;
	logic                  we_mark, we_data, we_val;
	oahm_pkg::mark_t       wr_mark;

	// probe step helpers
	logic [SB-1:0] cur_idx, i_next, free_idx;
	logic          probe_bank, is_empty, is_tomb, is_match, last_step;
	logic          hit, free_now, free_empty, tbl_full, cont;
	logic [CB-1:0] fill_next, used_next;
	logic          need_grow, out_load;
	logic [CB+1:0] fill3, mask2;

	assign cur_idx    = i_q & mask_q;
	assign i_next     = (i_q << 2) + i_q + SB'(1) + perturb_q[SB-1:0];
	assign probe_bank = placing_q ? ~bank_q : bank_q;
	assign is_empty   = (rd_mark_q == oahm_pkg::MARK_EMPTY);
	assign is_tomb    = (rd_mark_q == oahm_pkg::MARK_TOMB);
	assign is_match   = (rd_mark_q == oahm_pkg::MARK_LIVE) && (rd_code_q == code_q)
		&& (rd_key_q == key_q);
	assign last_step  = (n_q == LAST_STEP);

	// request probe outcome
	assign hit        = is_match;
	assign free_now   = is_empty || (last_step && (have_free_q || is_tomb) && !is_match);
	assign free_idx   = have_free_q ? free_q : cur_idx;
	assign free_empty = is_empty && !have_free_q;
	assign tbl_full   = last_step && !have_free_q && !is_tomb && !is_empty && !is_match;
	assign cont       = !hit && !free_now && !tbl_full;

	// growth check after a new key
	assign fill_next = fill_q + CB'(free_empty);
	assign used_next = used_q + CB'(1);
	assign fill3     = ((CB+2)'(fill_next) << 1) + (CB+2)'(fill_next);
	assign mask2     = (CB+2)'(mask_q) << 1;
	assign need_grow = fill3 > mask2;

	assign out_load = (state_q == oahm_pkg::ST_FINISH) && (!out_valid_q || rsp.ready);

	// sequencer: next state, memory ports
	always_comb begin
		state_d = state_q;
		rd_addr = {probe_bank, cur_idx};
		wr_addr = {bank_q, cur_idx};
		we_mark = 1'b0;
		we_data = 1'b0;
		we_val  = 1'b0;
		wr_mark = oahm_pkg::MARK_LIVE;
		unique case (state_q)
			oahm_pkg::ST_CLR: begin
				we_mark = 1'b1;
				wr_mark = oahm_pkg::MARK_EMPTY;
				wr_addr = {clr_bank_q, clr_idx_q};
				if (clr_idx_q == clr_last_q) state_d = clr_ret_q;
			end
			oahm_pkg::ST_IDLE: begin
				if (req.valid) begin
					if (req.op == oahm_pkg::OP_CLEAR) state_d = oahm_pkg::ST_CLR;
					else if (req.hash_code == inv_hash_q) state_d = oahm_pkg::ST_FINISH;
					else state_d = oahm_pkg::ST_PRB_RD;
				end
			end
			oahm_pkg::ST_PRB_RD: begin
				state_d = oahm_pkg::ST_PRB_CHK;
			end
			oahm_pkg::ST_PRB_CHK: begin
				if (placing_q) begin
					wr_addr = {~bank_q, cur_idx};
					if (is_empty) begin
						we_mark = 1'b1;
						we_data = 1'b1;
						we_val  = 1'b1;
						state_d = oahm_pkg::ST_GRW_NEXT;
					end else if (last_step) begin
						state_d = oahm_pkg::ST_GRW_NEXT;
					end else begin
						state_d = oahm_pkg::ST_PRB_RD;
					end
				end else if (cont) begin
					state_d = oahm_pkg::ST_PRB_RD;
				end else begin
					state_d = oahm_pkg::ST_FINISH;
					if (op_q == oahm_pkg::OP_INSERT) begin
						if (hit) begin
							we_val = 1'b1;
						end else if (free_now) begin
							wr_addr = {bank_q, free_idx};
							we_mark = 1'b1;
							we_data = 1'b1;
							we_val  = 1'b1;
							if (need_grow) state_d = oahm_pkg::ST_GRW_SIZE;
						end
					end else if (op_q == oahm_pkg::OP_REMOVE && hit) begin
						we_mark = 1'b1;
						wr_mark = oahm_pkg::MARK_TOMB;
					end
				end
			end
			oahm_pkg::ST_GRW_SIZE: begin
				if (!((CB+2)'(size_q) < need_q && size_q < CB'(MAX_SLOTS)))
					state_d = oahm_pkg::ST_CLR;
			end
			oahm_pkg::ST_GRW_RD: begin
				rd_addr = {bank_q, j_q[SB-1:0]};
				state_d = oahm_pkg::ST_GRW_CHK;
			end
			oahm_pkg::ST_GRW_CHK: begin
				state_d = (rd_mark_q == oahm_pkg::MARK_LIVE) ? oahm_pkg::ST_PRB_RD
					: oahm_pkg::ST_GRW_NEXT;
			end
			oahm_pkg::ST_GRW_NEXT: begin
				state_d = (j_q[SB-1:0] == old_mask_q) ? oahm_pkg::ST_FINISH
					: oahm_pkg::ST_GRW_RD;
			end
			oahm_pkg::ST_FINISH: begin
				if (out_load) state_d = oahm_pkg::ST_IDLE;
			end
			default: state_d = oahm_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= oahm_pkg::ST_CLR;
		else state_q <= state_d;
	end

	// slot memories: one write and one read port
	always_ff @(posedge clk) begin
		if (we_mark) mark_mem[wr_addr] <= wr_mark;
		if (we_data) begin
			key_mem[wr_addr]  <= key_q;
			code_mem[wr_addr] <= code_q;
		end
		if (we_val) val_mem[wr_addr] <= value_q;
		rd_mark_q <= mark_mem[rd_addr];
		rd_key_q  <= key_mem[rd_addr];
		rd_code_q <= code_mem[rd_addr];
		rd_val_q  <= val_mem[rd_addr];
	end

	// control state: counts, table shape, sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q      <= 1'b0;
			mask_q      <= SB'(MIN_SLOTS - 1);
			fill_q      <= '0;
			used_q      <= '0;
			inv_hash_q  <= oahm_pkg::INVALID_HASH_RST;
			clr_idx_q   <= '0;
			clr_last_q  <= SB'(MIN_SLOTS - 1);
			clr_bank_q  <= 1'b0;
			clr_ret_q   <= oahm_pkg::ST_IDLE;
			placing_q   <= 1'b0;
			have_free_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) inv_hash_q <= cfg.data;
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
			unique case (state_q)
				oahm_pkg::ST_CLR: begin
					clr_idx_q <= clr_idx_q + SB'(1);
				end
				oahm_pkg::ST_IDLE: begin
					have_free_q <= 1'b0;
					placing_q   <= 1'b0;
					if (req.valid && req.op == oahm_pkg::OP_CLEAR) begin
						fill_q     <= '0;
						used_q     <= '0;
						clr_idx_q  <= '0;
						clr_last_q <= mask_q;
						clr_bank_q <= bank_q;
						clr_ret_q  <= oahm_pkg::ST_FINISH;
					end
				end
				oahm_pkg::ST_PRB_CHK: begin
					if (placing_q) begin
						if (is_empty) begin
							fill_q <= fill_q + CB'(1);
							used_q <= used_next;
						end
					end else if (cont) begin
						if (is_tomb && !have_free_q) begin
							free_q      <= cur_idx;
							have_free_q <= 1'b1;
						end
					end else if (op_q == oahm_pkg::OP_INSERT && !hit && free_now) begin
						fill_q <= fill_next;
						used_q <= used_next;
					end else if (op_q == oahm_pkg::OP_REMOVE && hit) begin
						used_q <= used_q - CB'(1);
					end
				end
				oahm_pkg::ST_GRW_SIZE: begin
					if (!((CB+2)'(size_q) < need_q && size_q < CB'(MAX_SLOTS))) begin
						old_mask_q <= mask_q;
						mask_q     <= SB'(size_q - CB'(1));
						fill_q     <= '0;
						used_q     <= '0;
						clr_idx_q  <= '0;
						clr_last_q <= SB'(size_q - CB'(1));
						clr_bank_q <= ~bank_q;
						clr_ret_q  <= oahm_pkg::ST_GRW_RD;
					end
				end
				oahm_pkg::ST_GRW_CHK: begin
					placing_q <= 1'b1;
				end
				oahm_pkg::ST_GRW_NEXT: begin
					if (j_q[SB-1:0] == old_mask_q) begin
						bank_q    <= ~bank_q;
						placing_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// request word, probe cursor and result
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_value_q  <= found_q;
			out_count_q  <= used_q;
		end
		case (state_q)
			oahm_pkg::ST_IDLE: begin
				op_q      <= req.op;
				key_q     <= req.key;
				code_q    <= req.hash_code;
				value_q   <= req.value;
				i_q       <= req.hash_code[SB-1:0];
				perturb_q <= req.hash_code;
				n_q       <= '0;
				found_q   <= '0;
				status_q  <= (req.op != oahm_pkg::OP_CLEAR && req.hash_code == inv_hash_q)
					? oahm_pkg::STATUS_BAD_HASH : oahm_pkg::STATUS_OK;
			end
			oahm_pkg::ST_PRB_CHK: begin
				if (placing_q || cont) begin
					i_q       <= i_next;
					perturb_q <= perturb_q >> oahm_pkg::PERTURB_SHIFT;
					n_q       <= n_q + NB'(1);
				end else if (op_q == oahm_pkg::OP_INSERT) begin
					if (tbl_full) status_q <= oahm_pkg::STATUS_FULL;
					j_q    <= '0;
					size_q <= CB'(MIN_SLOTS);
					need_q <= (32'(used_next) > oahm_pkg::GROW_HALF_LIMIT)
						? ((CB+2)'(used_next) << 1) : ((CB+2)'(used_next) << 2);
				end else if (!hit) begin
					status_q <= oahm_pkg::STATUS_NOT_FOUND;
				end else if (op_q == oahm_pkg::OP_LOOKUP) begin
					found_q <= rd_val_q;
				end
			end
			oahm_pkg::ST_GRW_SIZE: begin
				if ((CB+2)'(size_q) < need_q && size_q < CB'(MAX_SLOTS))
					size_q <= size_q << 1;
			end
			oahm_pkg::ST_GRW_CHK: begin
				key_q     <= rd_key_q;
				code_q    <= rd_code_q;
				value_q   <= rd_val_q;
				i_q       <= rd_code_q[SB-1:0];
				perturb_q <= rd_code_q;
				n_q       <= '0;
			end
			oahm_pkg::ST_GRW_NEXT: begin
				j_q <= j_q + CB'(1);
			end
			default: ;
		endcase
	end

	assign req.ready      = (state_q == oahm_pkg::ST_IDLE);
	assign cfg.ready      = 1'b1;
	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.value_out  = out_value_q;
	assign rsp.live_count = out_count_q;

	// live entries never exceed occupied slots
	a_used_le_fill: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= fill_q) else $error("live count above fill count");

	// table size stays a power of two
	a_mask_pow2: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, mask_q} + (SB+1)'(1))) else $error("table mask not a power of two less one");

	// occupied slots fit in the table
	a_fill_fits: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= {1'b0, mask_q} + CB'(1)) else $error("fill count beyond table size");

endmodule
